### rtl/jdil_pkg.sv
`timescale 1ns / 1ps

package jdil_pkg;

    // accumulator width and fixed result width
    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;

    // ascii codes the lexer looks for
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_N,
        PH_NU,
        PH_NUL,
        PH_MINUS,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        KIND_INT,
        KIND_NULL,
        KIND_BAD,
        KIND_OVF
    } t_kind;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_mark;
    } t_in;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value_bits;
        t_kind                result_kind;
        logic [7:0]           terminator_byte;
        logic                 terminator_valid;
    } t_out;

endpackage

### rtl/jdil_lex.sv
`timescale 1ns / 1ps

module jdil_lex
    import jdil_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_in  i_item,
    input  logic i_signed_mode,
    output logic o_emit,
    output t_out o_res
);

    localparam logic [VALUE_WIDTH-1:0] LIM_NEG  = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] LIM_SMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] LIM_UMAX = {VALUE_WIDTH{1'b1}};

    t_phase                 r_phase, n_phase;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic                   r_ovf, n_ovf;
    logic                   r_has, n_has;

    logic [7:0]             w_c;
    logic                   w_digit;
    logic                   w_ws;
    logic [3:0]             w_d;
    logic [VALUE_WIDTH-1:0] w_lim;
    logic [VALUE_WIDTH+3:0] w_acc;
    logic                   w_acc_ovf;
    logic                   w_fin_ovf;
    logic [VALUE_WIDTH-1:0] w_val;
    logic                   w_add;
    logic                   w_clear;

    // byte classification
    assign w_c     = i_item.char_byte;
    assign w_digit = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_ws    = (w_c == CH_SPACE) || (w_c == CH_TAB) || (w_c == CH_LF) || (w_c == CH_CR);
    assign w_d     = 4'(w_c - CH_ZERO);

    // magnitude limit, negative numbers reach one further
    assign w_lim = r_neg ? LIM_NEG : (i_signed_mode ? LIM_SMAX : LIM_UMAX);

    // times ten plus digit, kept wide so the limit check is a plain compare
    assign w_acc = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                 + (VALUE_WIDTH+4)'(w_d);
    assign w_acc_ovf = w_acc > {4'b0000, w_lim};

    // number completion
    assign w_fin_ovf = r_ovf || (r_mag > w_lim);
    assign w_val     = r_neg ? (~r_mag + 1'b1) : r_mag;

    // next state and result
    always_comb begin
        n_phase = r_phase;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        n_has   = r_has;
        w_add   = 1'b0;
        w_clear = 1'b0;
        o_emit  = 1'b0;
        o_res.value_bits       = '0;
        o_res.result_kind      = KIND_BAD;
        o_res.terminator_byte  = '0;
        o_res.terminator_valid = 1'b0;

        if (i_item.end_mark) begin
            o_emit = 1'b1;
            if (r_phase == PH_DIGITS && r_has) begin
                if (w_fin_ovf) begin
                    o_res.result_kind = KIND_OVF;
                end else begin
                    o_res.result_kind = KIND_INT;
                    o_res.value_bits  = OUT_WIDTH'(w_val);
                end
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (w_ws) begin
                        n_phase = PH_IDLE;
                    end else if (w_c == CH_N) begin
                        n_phase = PH_N;
                    end else if (w_c == CH_MINUS && i_signed_mode) begin
                        n_neg   = 1'b1;
                        n_phase = PH_MINUS;
                    end else if (w_digit && w_c != CH_ZERO) begin
                        n_phase = PH_DIGITS;
                        w_add   = 1'b1;
                    end else begin
                        o_emit = 1'b1;
                    end
                end
                PH_N: begin
                    if (w_c == CH_U) begin
                        n_phase = PH_NU;
                    end else begin
                        o_emit = 1'b1;
                    end
                end
                PH_NU: begin
                    if (w_c == CH_L) begin
                        n_phase = PH_NUL;
                    end else begin
                        o_emit = 1'b1;
                    end
                end
                PH_NUL: begin
                    o_emit = 1'b1;
                    if (w_c == CH_L) begin
                        o_res.result_kind = KIND_NULL;
                    end
                end
                PH_MINUS: begin
                    if (w_digit) begin
                        n_phase = PH_DIGITS;
                        w_add   = 1'b1;
                    end else begin
                        // lone minus, byte goes back to the stream
                        o_emit = 1'b1;
                        o_res.terminator_byte  = w_c;
                        o_res.terminator_valid = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (w_digit) begin
                        w_add = 1'b1;
                    end else begin
                        o_emit = 1'b1;
                        o_res.terminator_byte  = w_c;
                        o_res.terminator_valid = 1'b1;
                        if (w_fin_ovf) begin
                            o_res.result_kind = KIND_OVF;
                        end else begin
                            o_res.result_kind = KIND_INT;
                            o_res.value_bits  = OUT_WIDTH'(w_val);
                        end
                    end
                end
                default: begin
                    w_clear = 1'b1;
                end
            endcase
        end

        // digit accumulation, sticky overflow stops further updates
        if (w_add) begin
            n_has = 1'b1;
            if (!r_ovf) begin
                if (w_acc_ovf) begin
                    n_ovf = 1'b1;
                end else begin
                    n_mag = w_acc[VALUE_WIDTH-1:0];
                end
            end
        end

        // every result returns the lexer to idle
        if (o_emit || w_clear) begin
            n_phase = PH_IDLE;
            n_mag   = '0;
            n_neg   = 1'b0;
            n_ovf   = 1'b0;
            n_has   = 1'b0;
        end
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_has   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
            r_has   <= n_has;
        end
    end

endmodule

### rtl/json_decimal_integer_lexer_top.sv
`timescale 1ns / 1ps

// Lexes one JSON integer from a byte stream and gives one result per number:
// the value (two's complement in signed mode), null, invalid format or
// overflow, together with the byte that ended the number when one is handed
// back. Bytes are taken at one per cycle while the input is not stalled; a
// byte passes an input register, then the lexer logic, and the result is held
// in a result register. The per-byte step is a single multiply-by-ten-and-add
// with a limit compare on the 64-bit accumulator. The input keeps flowing
// while a result waits, until a second result is due. signed_mode resets to 1
// and is written through the configuration port; the user must write it only
// while no request is in flight, as the block does not enforce this.
module json_decimal_integer_lexer_top
    import jdil_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    logic r_signed_mode;
    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;

    logic w_emit;
    t_out w_res;
    logic w_out_free;
    logic w_proc;
    logic w_accept;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_signed_mode <= i_cfg_data;
        end
    end

    // flow control between input stage and result stage
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && (!w_emit || w_out_free);
    assign o_in_stall = r_in_valid && !w_proc;
    assign w_accept   = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
    end

    jdil_lex u_lex (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_proc),
        .i_item        (r_in),
        .i_signed_mode (r_signed_mode),
        .o_emit        (w_emit),
        .o_res         (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_proc && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_proc && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // only an integer result carries a value
    a_value_only_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind != KIND_INT) |-> (r_out.value_bits == '0))
        else $error("non-integer result carries a value");

    // a byte is handed back only after a number or a lone minus
    a_term_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.terminator_valid) |->
        (r_out.result_kind != KIND_NULL))
        else $error("terminator returned with a null result");

    // no returned byte means a zero byte field
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.terminator_valid) |-> (r_out.terminator_byte == 8'h00))
        else $error("terminator byte set without terminator valid");

    // the input side stalls only while a result is blocked downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && w_emit && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // a blocked result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_proc || !w_emit)
        else $error("result overwritten while stalled");

endmodule
